// ===== design/lti_pkg.sv =====
// ----------------------------------------------------------------------------
// lti_pkg
// Shared constants, types and helpers for the 3D LUT trilinear interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package lti_pkg;

  // Table geometry and value width
  localparam int LUT_POINTS  = 17;
  localparam int VALUE_BITS  = 16;
  localparam int TABLE_DEPTH = LUT_POINTS * LUT_POINTS * LUT_POINTS;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int CELL_BITS   = $clog2(LUT_POINTS);

  // Port field widths (fixed)
  localparam int INDEX_BITS  = 13;
  localparam int ENTRY_BITS  = 16;
  localparam int COMP_BITS   = 18;
  localparam int RESULT_BITS = 16;

  // Fixed point: 1.0 = 2^16, fraction runs 0..1.0 inclusive
  localparam int ONE_Q16    = 65536;
  localparam int FRAC_BITS  = 17;
  localparam int SCALE_BITS = FRAC_BITS + $clog2(LUT_POINTS);
  localparam int INT_BITS   = SCALE_BITS - 16;

  // Blend datapath: (VALUE_BITS+1) signed diff times (FRAC_BITS+1) signed fraction
  localparam int PROD_BITS  = VALUE_BITS + FRAC_BITS + 2;

  localparam int NUM_CORNERS = 8;
  localparam int NUM_STEPS   = 7;

  localparam int COPY_IN_BITS  = (VALUE_BITS < ENTRY_BITS)  ? VALUE_BITS : ENTRY_BITS;
  localparam int COPY_OUT_BITS = (VALUE_BITS < RESULT_BITS) ? VALUE_BITS : RESULT_BITS;

  localparam logic [FRAC_BITS-1:0] FRAC_ONE = FRAC_BITS'(ONE_Q16);

  // Action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [CELL_BITS-1:0]  cell_t;
  typedef logic [FRAC_BITS-1:0]  frac_t;

  typedef struct packed {
    cell_t cell_idx;
    frac_t frac;
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_DRAIN,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  // Clamp to [0, 1.0], scale by LUT_POINTS-1, split into cell and fraction.
  function automatic axis_t split_axis(input logic signed [COMP_BITS-1:0] comp);
    logic [FRAC_BITS-1:0]  c;
    logic [SCALE_BITS-1:0] u;
    logic [INT_BITS-1:0]   ip;
    axis_t                 r;
    if (comp[COMP_BITS-1]) begin
      c = '0;
    end else if (comp > $signed(COMP_BITS'(ONE_Q16))) begin
      c = FRAC_ONE;
    end else begin
      c = comp[FRAC_BITS-1:0];
    end
    u  = SCALE_BITS'(c) * SCALE_BITS'(LUT_POINTS - 1);
    ip = u[SCALE_BITS-1:16];
    if (ip > INT_BITS'(LUT_POINTS - 2)) begin
      r.cell_idx = CELL_BITS'(LUT_POINTS - 2);
      r.frac     = FRAC_BITS'(u - (SCALE_BITS'(LUT_POINTS - 2) << 16));
    end else begin
      r.cell_idx = CELL_BITS'(ip);
      r.frac     = {1'b0, u[15:0]};
    end
    return r;
  endfunction

  // Corner k = {dr, dg, db}: offset from the cell's base entry.
  function automatic addr_t corner_offset(input logic [2:0] k);
    addr_t off;
    off = '0;
    if (k[2]) off = off + ADDR_BITS'(LUT_POINTS * LUT_POINTS);
    if (k[1]) off = off + ADDR_BITS'(LUT_POINTS);
    if (k[0]) off = off + ADDR_BITS'(1);
    return off;
  endfunction

  function automatic value_t entry_to_value(input logic [ENTRY_BITS-1:0] x);
    value_t r;
    r = '0;
    r[COPY_IN_BITS-1:0] = x[COPY_IN_BITS-1:0];
    return r;
  endfunction

  function automatic logic [RESULT_BITS-1:0] value_to_result(input value_t x);
    logic [RESULT_BITS-1:0] r;
    r = '0;
    r[COPY_OUT_BITS-1:0] = x[COPY_OUT_BITS-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/lti_ram.sv =====
// ----------------------------------------------------------------------------
// lti_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/lut_trilinear_interpolator_core.sv =====
// Lookups are not overlapped: no new transaction is taken until the last
//   lookup's result is in the output register. Each lookup makes eight serial
//   corner reads from the single table read port and seven blends through one
//   shared multiplier. Table writes are accepted back to back.
// Reset (rst, synchronous, active high) clears control only; table contents are
//   undefined until written.
// ----------------------------------------------------------------------------
// lut_trilinear_interpolator_core
// 3D LUT with trilinear interpolation; table in one synchronous RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module lut_trilinear_interpolator_core import lti_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         action,
  input  wire logic [INDEX_BITS-1:0]        entry_index,
  input  wire logic [ENTRY_BITS-1:0]        entry_value,
  input  wire logic signed [COMP_BITS-1:0]  red,
  input  wire logic signed [COMP_BITS-1:0]  green,
  input  wire logic signed [COMP_BITS-1:0]  blue,
  // output channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [RESULT_BITS-1:0]            interpolated_value
);

  // --------------------------------------------------------------------------
  // Flow:
  //   IDLE  : take a transaction. Writes go straight into the RAM.
  //           Lookups register the per-axis cell/fraction split.
  //   ADDR  : flat base address of the cell's low corner.
  //   READ  : eight corner reads, order {dr,dg,db} = 0..7.
  //   DRAIN : last read data lands.
  //   MUL/ADD: seven blends through one unit. Corners sit in a small queue;
  //           each blend pops the two head entries and pushes the result:
  //           4 blends along blue, 2 along green, 1 along red.
  //   DONE  : wait for the output register, then back to IDLE.
  // --------------------------------------------------------------------------

  state_t state, state_next;

  // Control outputs of the sequencer
  logic   accept;
  logic   wr_en;
  logic   rd_en;
  logic   load_out;

  // Per-axis split
  axis_t  ax_r, ax_g, ax_b;
  addr_t  base;
  addr_t  rd_addr;
  value_t rd_data;

  logic [2:0] rd_cnt;
  logic       rd_pend;

  // Corner / partial-result queue; head is w[0]
  value_t     w [NUM_CORNERS];
  logic [3:0] w_count;
  logic [2:0] step;

  // Blend unit
  frac_t                        frac_sel;
  logic signed [VALUE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]    frac_s;
  logic signed [PROD_BITS-1:0]  product_full;
  logic signed [PROD_BITS-1:0]  prod;
  value_t                       op_a;
  logic signed [PROD_BITS-1:0]  quo;
  logic signed [PROD_BITS-1:0]  sum;
  value_t                       blend_res;

  logic in_range;

  assign in_range = 32'(entry_index) < 32'(TABLE_DEPTH);
  assign accept   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Table RAM
  // --------------------------------------------------------------------------
  assign rd_addr = base + corner_offset(rd_cnt);

  lti_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_BITS'(entry_index)),
    .wr_data (entry_to_value(entry_value)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && action == ACT_LOOKUP) state_next = ST_ADDR;
      end
      ST_ADDR:  state_next = ST_READ;
      ST_READ: begin
        if (rd_cnt == 3'(NUM_CORNERS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_MUL;
      ST_MUL:   state_next = ST_ADD;
      ST_ADD: begin
        if (step == 3'(NUM_STEPS - 1)) state_next = ST_DONE;
        else state_next = ST_MUL;
      end
      ST_DONE: begin
        if (load_out) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: in_ready = !rst;
      ST_READ: rd_en    = 1'b1;
      ST_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
    wr_en = accept && action == ACT_WRITE && in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Blend unit: a + ((b - a) * f) >>> 16, multiply registered before the add
  // --------------------------------------------------------------------------
  always_comb begin
    if (step < 3'd4) begin
      frac_sel = ax_b.frac;
    end else if (step < 3'd6) begin
      frac_sel = ax_g.frac;
    end else begin
      frac_sel = ax_r.frac;
    end
  end

  assign diff         = $signed({1'b0, w[1]}) - $signed({1'b0, w[0]});
  assign frac_s       = $signed({1'b0, frac_sel});
  assign product_full = PROD_BITS'(diff) * PROD_BITS'(frac_s);
  assign quo          = prod >>> 16;
  assign sum          = quo + $signed(PROD_BITS'(op_a));
  assign blend_res    = sum[VALUE_BITS-1:0];

  // --------------------------------------------------------------------------
  // Datapath payload
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept && action == ACT_LOOKUP) begin
      ax_r <= split_axis(red);
      ax_g <= split_axis(green);
      ax_b <= split_axis(blue);
    end

    if (state == ST_ADDR) begin
      base <= ADDR_BITS'(ax_r.cell_idx) * ADDR_BITS'(LUT_POINTS * LUT_POINTS)
            + ADDR_BITS'(ax_g.cell_idx) * ADDR_BITS'(LUT_POINTS)
            + ADDR_BITS'(ax_b.cell_idx);
    end

    if (rd_pend) begin
      w[w_count[2:0]] <= rd_data;
    end else if (state == ST_MUL) begin
      prod <= product_full;
      op_a <= w[0];
      for (int i = 0; i < NUM_CORNERS - 2; i++) begin
        w[i] <= w[i + 2];
      end
    end else if (state == ST_ADD) begin
      w[w_count[2:0]] <= blend_res;
    end

    if (load_out) begin
      interpolated_value <= value_to_result(w[0]);
    end
  end

  // --------------------------------------------------------------------------
  // Counters and valid flags
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt    <= '0;
      rd_pend   <= 1'b0;
      w_count   <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= (state == ST_READ);

      case (state)
        ST_ADDR: begin
          rd_cnt  <= '0;
          w_count <= '0;
          step    <= '0;
        end
        ST_READ: rd_cnt <= rd_cnt + 3'd1;
        ST_MUL:  w_count <= w_count - 4'd2;
        ST_ADD: begin
          w_count <= w_count + 4'd1;
          step    <= step + 3'd1;
        end
        default: ;
      endcase

      if (rd_pend) begin
        w_count <= w_count + 4'd1;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/lti_checker.sv =====
// ----------------------------------------------------------------------------
// lti_checker
// Port-level assertions for the LUT interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lti_checker import lti_pkg::*; (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        action,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [RESULT_BITS-1:0]      interpolated_value
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(interpolated_value))
    else $error("stalled result changed");

  // A lookup occupies the engine: no new transaction on the next cycle.
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_LOOKUP |=> !in_ready)
    else $error("input ready right after a lookup");

  // A table write does not stall the input: ready stays high after it.
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_WRITE |=> in_ready)
    else $error("input stalled after a table write");

  // Posting a result frees the engine in the same edge.
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("engine still busy after posting a result");

endmodule

bind lut_trilinear_interpolator_core lti_checker u_lti_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .action             (action),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .interpolated_value (interpolated_value)
);

`default_nettype wire

// ===== tb/sv/tb_lut_trilinear_interpolator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lut_trilinear_interpolator_core
// Self-checking bench for the 3D LUT trilinear interpolator. Table writes and
// colour lookups go in over valid/ready. A shadow copy of the table predicts
// each blend, and results are checked in order against the queued predictions.
// ----------------------------------------------------------------------------

module tb_lut_trilinear_interpolator_core;
  import lti_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  localparam int TOTAL_ITEMS  = 750;       // input transactions, writes and lookups
  localparam int DRAIN_CYCLES = 40;        // idle watch for stray results after the last expected one
  localparam int CYCLE_LIMIT  = 600000;
  localparam int CELL_SPAN    = ONE_Q16 / (LUT_POINTS - 1);  // component span of one cell

  localparam logic signed [COMP_BITS-1:0] COMP_ONE = COMP_BITS'(ONE_Q16);
  localparam logic signed [COMP_BITS-1:0] COMP_MIN = {1'b1, {(COMP_BITS-1){1'b0}}};
  localparam logic signed [COMP_BITS-1:0] COMP_MAX = {1'b0, {(COMP_BITS-1){1'b1}}};

  // --------------------------------------------------------------------------
  // Shadow table plus the queue of blends still owed by the block.
  // --------------------------------------------------------------------------
  class lut_lookup_tracker;
    value_t                 shadow_lut[TABLE_DEPTH];
    bit                     entry_known[TABLE_DEPTH];
    logic [RESULT_BITS-1:0] expected_blends[$];
    int                     errors;

    static function int flat_index(int r, int g, int b);
      return (r * LUT_POINTS + g) * LUT_POINTS + b;
    endfunction

    // clamp to [0, 1.0], scale, split into cell and a fraction of up to 1.0
    static function void split_component(input logic signed [COMP_BITS-1:0] comp,
                                         output int cell_idx, output longint frac);
      longint c;
      longint u;
      c = comp;
      if (c < 0) c = 0;
      if (c > ONE_Q16) c = ONE_Q16;
      u = c * (LUT_POINTS - 1);
      cell_idx = int'(u / ONE_Q16);
      if (cell_idx > LUT_POINTS - 2) cell_idx = LUT_POINTS - 2;
      frac = u - longint'(cell_idx) * ONE_Q16;
    endfunction

    // a + floor((b - a) * f / 2^16)
    static function longint mix(longint a, longint b, longint f);
      return a + (((b - a) * f) >>> 16);
    endfunction

    function longint corner(int r, int g, int b);
      return longint'(shadow_lut[flat_index(r, g, b)]);
    endfunction

    // blue first, then green, then red
    function logic [RESULT_BITS-1:0] blend_lookup(logic signed [COMP_BITS-1:0] r,
                                                  logic signed [COMP_BITS-1:0] g,
                                                  logic signed [COMP_BITS-1:0] b);
      int     cr, cg, cb;
      longint fr, fg, fb;
      longint along_b[4];
      longint along_g[2];
      longint v;
      split_component(r, cr, fr);
      split_component(g, cg, fg);
      split_component(b, cb, fb);
      for (int k = 0; k < 4; k++) begin
        along_b[k] = mix(corner(cr + k / 2, cg + k % 2, cb),
                         corner(cr + k / 2, cg + k % 2, cb + 1), fb);
      end
      along_g[0] = mix(along_b[0], along_b[1], fg);
      along_g[1] = mix(along_b[2], along_b[3], fg);
      v = mix(along_g[0], along_g[1], fr);
      if (v < 0) v = 0;
      return RESULT_BITS'(v);
    endfunction

    function void note_transaction(logic act, logic [INDEX_BITS-1:0] idx,
                                   logic [ENTRY_BITS-1:0] val,
                                   logic signed [COMP_BITS-1:0] r,
                                   logic signed [COMP_BITS-1:0] g,
                                   logic signed [COMP_BITS-1:0] b);
      if (act == ACT_WRITE) begin
        // out-of-range index: dropped silently
        if (idx < TABLE_DEPTH) begin
          shadow_lut[idx]  = value_t'(val);
          entry_known[idx] = 1'b1;
        end
      end else begin
        expected_blends.push_back(blend_lookup(r, g, b));
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_blend(logic [RESULT_BITS-1:0] got);
      logic [RESULT_BITS-1:0] want;
      if (expected_blends.size() == 0) begin
        report($sformatf("result %h with no lookup outstanding", got));
      end else begin
        want = expected_blends.pop_front();
        if (got !== want) report($sformatf("interpolated_value %h, expected %h", got, want));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic                          action;
  logic [INDEX_BITS-1:0]         entry_index;
  logic [ENTRY_BITS-1:0]         entry_value;
  logic signed [COMP_BITS-1:0]   red;
  logic signed [COMP_BITS-1:0]   green;
  logic signed [COMP_BITS-1:0]   blue;
  logic                          out_valid;
  logic                          out_ready;
  logic [RESULT_BITS-1:0]        interpolated_value;

  lut_trilinear_interpolator_core DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (action),
    .entry_index        (entry_index),
    .entry_value        (entry_value),
    .red                (red),
    .green              (green),
    .blue               (blue),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .interpolated_value (interpolated_value)
  );

  lut_lookup_tracker tracker;
  bit                in_steady;     // stretch with no gaps on the input side
  bit                out_steady;    // stretch with no stalls on the output side
  int                stall_left;
  int                cycle_count;
  int                items_sent;    // accepted input transactions

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL lut_trilinear_interpolator_core");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(bit steady);
    int sel;
    sel = $urandom_range(0, 99);
    if (steady || sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check every result, stall ready at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_blend(interpolated_value);
      if ($urandom_range(0, 99) < 2) out_steady = !out_steady;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap(out_steady) : 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Valid stays high across back-to-back transactions; it only drops for a gap.
  task automatic send_item(input logic act, input logic [INDEX_BITS-1:0] idx,
                           input logic [ENTRY_BITS-1:0] val,
                           input logic signed [COMP_BITS-1:0] r,
                           input logic signed [COMP_BITS-1:0] g,
                           input logic signed [COMP_BITS-1:0] b);
    int gap;
    gap = pick_gap(in_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    entry_index <= idx;
    entry_value <= val;
    red         <= r;
    green       <= g;
    blue        <= b;
    do @(posedge clk); while (!in_ready);
    tracker.note_transaction(act, idx, val, r, g, b);
    items_sent++;
  endtask

  function automatic logic [ENTRY_BITS-1:0] random_entry();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return ENTRY_BITS'($urandom);
  endfunction

  // Mostly in range and bunched into a few cells so entries get reused;
  // some anywhere in the 18-bit range, some exactly 1.0.
  function automatic logic signed [COMP_BITS-1:0] random_component();
    int sel;
    int c;
    sel = $urandom_range(0, 99);
    if (sel < 12) return COMP_BITS'($urandom);
    if (sel < 16) return COMP_ONE;
    if (sel < 40) c = $urandom_range(0, LUT_POINTS - 2);
    else c = ($urandom_range(0, 3) * (LUT_POINTS - 2)) / 3;
    return COMP_BITS'(c * CELL_SPAN + $urandom_range(0, CELL_SPAN - 1));
  endfunction

  // Half uniform over the table, half on corners of cells lookups tend to hit.
  function automatic logic [INDEX_BITS-1:0] random_live_index();
    int     cr, cg, cb;
    longint f;
    if ($urandom_range(0, 1) == 0) return INDEX_BITS'($urandom_range(0, TABLE_DEPTH - 1));
    lut_lookup_tracker::split_component(random_component(), cr, f);
    lut_lookup_tracker::split_component(random_component(), cg, f);
    lut_lookup_tracker::split_component(random_component(), cb, f);
    return INDEX_BITS'(lut_lookup_tracker::flat_index(cr + $urandom_range(0, 1),
                                                      cg + $urandom_range(0, 1),
                                                      cb + $urandom_range(0, 1)));
  endfunction

  // A lookup may only touch written entries, so any corner of the target
  // cell not yet written gets a write transaction first.
  task automatic request_blend(input logic signed [COMP_BITS-1:0] r,
                               input logic signed [COMP_BITS-1:0] g,
                               input logic signed [COMP_BITS-1:0] b);
    int     cr, cg, cb, idx;
    longint f;
    lut_lookup_tracker::split_component(r, cr, f);
    lut_lookup_tracker::split_component(g, cg, f);
    lut_lookup_tracker::split_component(b, cb, f);
    for (int k = 0; k < 8; k++) begin
      idx = lut_lookup_tracker::flat_index(cr + k / 4, cg + (k / 2) % 2, cb + k % 2);
      if (!tracker.entry_known[idx]) begin
        send_item(ACT_WRITE, INDEX_BITS'(idx), random_entry(), COMP_BITS'($urandom),
                  COMP_BITS'($urandom), COMP_BITS'($urandom));
      end
    end
    // entry fields carry junk on a lookup; the block must ignore them
    send_item(ACT_LOOKUP, INDEX_BITS'($urandom), ENTRY_BITS'($urandom), r, g, b);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int sel;
    tracker     = new;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    action      <= ACT_WRITE;
    entry_index <= '0;
    entry_value <= '0;
    red         <= '0;
    green       <= '0;
    blue        <= '0;
    out_ready   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Origin cell as a checkerboard of zero and full scale, so every blend
    // step runs both up and down across the widest difference.
    for (int k = 0; k < 8; k++) begin
      send_item(ACT_WRITE,
                INDEX_BITS'(lut_lookup_tracker::flat_index(k / 4, (k / 2) % 2, k % 2)),
                (((k / 4) + (k / 2) + k) % 2 == 1) ? '1 : '0,
                COMP_MIN, COMP_MAX, COMP_ONE);
    end
    // writes past the table end: dropped, no result
    send_item(ACT_WRITE, INDEX_BITS'(TABLE_DEPTH), '1, '0, '0, '0);
    send_item(ACT_WRITE, '1, '1, COMP_MAX, COMP_MIN, COMP_MAX);
    // last entry of the table: far corner of the top cell
    send_item(ACT_WRITE, INDEX_BITS'(TABLE_DEPTH - 1), '1, '0, '0, '0);

    request_blend('0, '0, '0);
    // negatives clamp to zero
    request_blend(COMP_MIN, -18'sd1, -COMP_ONE);
    // half a cell on each axis, then fractions near zero and near one
    request_blend(18'sd2048, 18'sd2048, 18'sd2048);
    request_blend(COMP_BITS'(CELL_SPAN - 1), 18'sd1, 18'sd2048);
    // exactly 1.0: last cell, fraction 1.0, far corner
    request_blend(COMP_ONE, COMP_ONE, COMP_ONE);
    // above 1.0 clamps to 1.0
    request_blend(COMP_MAX, COMP_ONE + 18'sd1, 18'sd100000);
    request_blend(COMP_ONE - 18'sd1, '0, COMP_ONE);
    // overwrite a corner already read, then read it again
    send_item(ACT_WRITE, '0, '1, '0, '0, '0);
    request_blend(18'sd1000, 18'sd2000, 18'sd3000);

    // Random mix: lookups (with any missing corners written first), writes
    // inside the table and writes past its end.
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 99) < 3) in_steady = !in_steady;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        request_blend(random_component(), random_component(), random_component());
      end else if (sel < 88) begin
        send_item(ACT_WRITE, random_live_index(), random_entry(), COMP_BITS'($urandom),
                  COMP_BITS'($urandom), COMP_BITS'($urandom));
      end else begin
        send_item(ACT_WRITE, INDEX_BITS'($urandom_range(TABLE_DEPTH, 2**INDEX_BITS - 1)),
                  random_entry(), COMP_BITS'($urandom), COMP_BITS'($urandom),
                  COMP_BITS'($urandom));
      end
    end
    in_valid <= 1'b0;

    // wait out outstanding lookups, then watch for stray results
    while (tracker.expected_blends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("PASS lut_trilinear_interpolator_core");
    end else begin
      $display("FAIL lut_trilinear_interpolator_core");
    end
    $finish;
  end

endmodule
